// File: rtl/core/sbmq_pkg.sv
// Package for the shared buffer multi-queue block.
// Store sizes, derived widths, status codes and payload types.
// No dependencies.
package sbmq_pkg;

    localparam int ENTRIES = 64;
    localparam int QUEUES  = 4;

    localparam int DATA_W  = 32;
    localparam int QID_W   = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int LINK_W  = $clog2(ENTRIES + 1);
    localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LINK_W-1:0] t_link;
    typedef logic [QIDX_W-1:0] t_qidx;
    typedef logic [QID_W-1:0]  t_qid;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_link NULL_LINK = t_link'(ENTRIES);

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

endpackage

// File: rtl/core/shared_buffer_multi_queue.sv
// Top level of the shared buffer multi-queue: link and data memories, queue heads and tails,
// free list and the stream handshake.
// Depends on sbmq_pkg.
//
// QUEUES first-in first-out queues share one store of ENTRIES slots; each slot holds a data
// word in one memory and a link to the next slot in another, and unowned slots are chained
// on a free list. Every input transfer is a push (tuser bit 0 low) or a pop (high) on the
// queue in tuser bits 2:1, and yields exactly one output transfer carrying a status (ok,
// full, empty) and, for a successful pop, the dequeued word. Each item passes an accept step,
// reading the link and data memories at the free-list or queue head, then an update step,
// writing the updated link back and issuing the result; no new item is taken before the
// update step is done. A result waiting at the output register holds the update step until it
// is taken. No clearing pass follows reset: per-slot valid bits supply the initial link chain.
module shared_buffer_multi_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value
    input  logic [2:0]  s_axis_tuser,   // mode, queue_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_out
    output logic [1:0]  m_axis_tuser    // status
);

    sbmq_pkg::t_data   r_data_mem [sbmq_pkg::ENTRIES];
    sbmq_pkg::t_link   r_link_mem [sbmq_pkg::ENTRIES];
    logic              r_link_vld [sbmq_pkg::ENTRIES];
    sbmq_pkg::t_link   r_qhead    [sbmq_pkg::QUEUES];
    sbmq_pkg::t_slot   r_qtail    [sbmq_pkg::QUEUES];
    sbmq_pkg::t_link   r_free_head;

    logic              r_busy;
    logic              r_mode;
    sbmq_pkg::t_qid    r_qid;
    sbmq_pkg::t_data   r_value;
    sbmq_pkg::t_link   r_slot;
    logic              r_is_tail;
    sbmq_pkg::t_data   r_data_rd;
    sbmq_pkg::t_link   r_link_rd;
    logic              r_rd_vld;

    logic              r_m_valid;
    sbmq_pkg::t_status r_m_status;
    sbmq_pkg::t_data   r_m_data;

    logic              s_accept;
    logic              s_mode;
    sbmq_pkg::t_qid    s_qid;
    logic              s_q_ok;
    sbmq_pkg::t_qidx   s_qidx;
    sbmq_pkg::t_link   s_slot;
    sbmq_pkg::t_slot   s_raddr;

    logic              c_commit;
    logic              c_q_ok;
    sbmq_pkg::t_qidx   c_qidx;
    logic              c_slot_ok;
    logic              c_push_ok;
    logic              c_pop_ok;
    logic              c_q_empty;
    sbmq_pkg::t_link   c_link;
    sbmq_pkg::t_link   c_next;
    logic              c_link_we;
    sbmq_pkg::t_slot   c_link_waddr;
    sbmq_pkg::t_link   c_link_wdata;

    assign s_axis_tready = !r_busy;
    assign s_accept      = s_axis_tvalid && !r_busy;

    always_comb begin
        s_mode  = s_axis_tuser[0];
        s_qid   = s_axis_tuser[2:1];
        s_q_ok  = int'(s_qid) < sbmq_pkg::QUEUES;
        s_qidx  = sbmq_pkg::t_qidx'(s_qid);
        if (s_mode == sbmq_pkg::MODE_POP) begin
            s_slot = s_q_ok ? r_qhead[s_qidx] : sbmq_pkg::NULL_LINK;
        end else begin
            s_slot = r_free_head;
        end
        s_raddr = s_slot[sbmq_pkg::SLOT_W-1:0];
    end

    always_comb begin
        c_commit  = r_busy && (!r_m_valid || m_axis_tready);
        c_q_ok    = int'(r_qid) < sbmq_pkg::QUEUES;
        c_qidx    = sbmq_pkg::t_qidx'(r_qid);
        c_slot_ok = r_slot < sbmq_pkg::LINK_W'(sbmq_pkg::ENTRIES);
        c_push_ok = (r_mode == sbmq_pkg::MODE_PUSH) && c_q_ok && c_slot_ok;
        c_pop_ok  = (r_mode == sbmq_pkg::MODE_POP) && c_q_ok && c_slot_ok;
        c_q_empty = !(r_qhead[c_qidx] < sbmq_pkg::LINK_W'(sbmq_pkg::ENTRIES));
        if (r_rd_vld) begin
            c_link = r_link_rd;
        end else begin
            c_link = sbmq_pkg::LINK_W'(r_slot[sbmq_pkg::SLOT_W-1:0])
                     + sbmq_pkg::LINK_W'(1);
        end
        if ((c_link < sbmq_pkg::LINK_W'(sbmq_pkg::ENTRIES))
            && !((r_mode == sbmq_pkg::MODE_POP) && r_is_tail)) begin
            c_next = c_link;
        end else begin
            c_next = sbmq_pkg::NULL_LINK;
        end
        c_link_we    = c_commit && ((c_push_ok && !c_q_empty) || c_pop_ok);
        c_link_waddr = c_pop_ok ? r_slot[sbmq_pkg::SLOT_W-1:0] : r_qtail[c_qidx];
        c_link_wdata = c_pop_ok ? r_free_head : r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (c_commit && c_push_ok) begin
            r_data_mem[r_slot[sbmq_pkg::SLOT_W-1:0]] <= r_value;
        end
        if (s_accept) begin
            r_data_rd <= r_data_mem[s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_link_we) begin
            r_link_mem[c_link_waddr] <= c_link_wdata;
        end
        if (s_accept) begin
            r_link_rd <= r_link_mem[s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sbmq_pkg::ENTRIES; i++) begin
                r_link_vld[i] <= 1'b0;
            end
        end else if (c_link_we) begin
            r_link_vld[c_link_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode    <= s_mode;
            r_qid     <= s_qid;
            r_value   <= s_axis_tdata;
            r_slot    <= s_slot;
            r_is_tail <= (s_raddr == r_qtail[s_qidx]);
            r_rd_vld  <= r_link_vld[s_raddr];
        end
        if (c_commit && c_push_ok) begin
            r_qtail[c_qidx] <= r_slot[sbmq_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            for (int i = 0; i < sbmq_pkg::QUEUES; i++) begin
                r_qhead[i] <= sbmq_pkg::NULL_LINK;
            end
        end else if (c_commit) begin
            if (c_push_ok) begin
                r_free_head <= c_next;
                if (c_q_empty) begin
                    r_qhead[c_qidx] <= r_slot;
                end
            end else if (c_pop_ok) begin
                r_qhead[c_qidx] <= c_next;
                r_free_head     <= r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_busy <= 1'b1;
            end else if (c_commit) begin
                r_busy <= 1'b0;
            end
            if (c_commit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_commit) begin
            if (r_mode == sbmq_pkg::MODE_POP) begin
                r_m_status <= c_pop_ok ? sbmq_pkg::ST_OK : sbmq_pkg::ST_EMPTY;
                r_m_data   <= c_pop_ok ? r_data_rd : '0;
            end else begin
                r_m_status <= c_push_ok ? sbmq_pkg::ST_OK : sbmq_pkg::ST_FULL;
                r_m_data   <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_status;

endmodule

// File: test/tb_shared_buffer_multi_queue.sv
`timescale 1ns / 100ps
// Testbench for shared_buffer_multi_queue: push and pop transfers checked against a linked-slot
// predictor of the shared store, with random bursts, receiver stalls and one long hold-off.
// Depends on sbmq_pkg and the shared_buffer_multi_queue RTL.

typedef struct packed {
    sbmq_pkg::t_status status;
    sbmq_pkg::t_data   data;
} t_queue_reply;

class queue_store_model;
    sbmq_pkg::t_data slot_data [sbmq_pkg::ENTRIES];
    sbmq_pkg::t_link slot_link [sbmq_pkg::ENTRIES];
    sbmq_pkg::t_link queue_head [sbmq_pkg::QUEUES];
    sbmq_pkg::t_link queue_tail [sbmq_pkg::QUEUES];
    sbmq_pkg::t_link free_head;
    t_queue_reply    replies_due [$];
    int              errors;
    int              pushes_ok;
    int              pushes_full;
    int              pops_ok;
    int              pops_empty;

    function new();
        for (int i = 0; i < sbmq_pkg::ENTRIES; i++) begin
            slot_data[i] = '0;
            slot_link[i] = sbmq_pkg::t_link'(i + 1);
        end
        for (int q = 0; q < sbmq_pkg::QUEUES; q++) begin
            queue_head[q] = sbmq_pkg::NULL_LINK;
            queue_tail[q] = '0;
        end
        free_head   = '0;
        errors      = 0;
        pushes_ok   = 0;
        pushes_full = 0;
        pops_ok     = 0;
        pops_empty  = 0;
    endfunction

    function bit holds_slot(sbmq_pkg::t_link code);
        return code < sbmq_pkg::ENTRIES;
    endfunction

    function void note_request(logic mode, sbmq_pkg::t_qid qid, sbmq_pkg::t_data value);
        t_queue_reply    reply;
        sbmq_pkg::t_link slot;
        sbmq_pkg::t_link next_link;
        reply.status = sbmq_pkg::ST_OK;
        reply.data   = '0;
        if (mode == sbmq_pkg::MODE_PUSH) begin
            if (qid >= sbmq_pkg::QUEUES || !holds_slot(free_head)) begin
                reply.status = sbmq_pkg::ST_FULL;
                pushes_full++;
            end else begin
                slot      = free_head;
                next_link = slot_link[slot[sbmq_pkg::SLOT_W-1:0]];
                free_head = holds_slot(next_link) ? next_link : sbmq_pkg::NULL_LINK;
                if (!holds_slot(queue_head[qid])) begin
                    queue_head[qid] = slot;
                end else if (holds_slot(queue_tail[qid])) begin
                    slot_link[queue_tail[qid][sbmq_pkg::SLOT_W-1:0]] = slot;
                end
                slot_link[slot[sbmq_pkg::SLOT_W-1:0]] = sbmq_pkg::NULL_LINK;
                queue_tail[qid] = slot;
                slot_data[slot[sbmq_pkg::SLOT_W-1:0]] = value;
                pushes_ok++;
            end
        end else begin
            if (qid >= sbmq_pkg::QUEUES || !holds_slot(queue_head[qid])) begin
                reply.status = sbmq_pkg::ST_EMPTY;
                pops_empty++;
            end else begin
                slot            = queue_head[qid];
                next_link       = slot_link[slot[sbmq_pkg::SLOT_W-1:0]];
                queue_head[qid] = holds_slot(next_link) ? next_link : sbmq_pkg::NULL_LINK;
                slot_link[slot[sbmq_pkg::SLOT_W-1:0]] = free_head;
                free_head       = slot;
                reply.data      = slot_data[slot[sbmq_pkg::SLOT_W-1:0]];
                pops_ok++;
            end
        end
        replies_due.push_back(reply);
    endfunction

    function void check_reply(sbmq_pkg::t_status status, sbmq_pkg::t_data data);
        t_queue_reply want;
        if (replies_due.size() == 0) begin
            $display("%0t: unexpected result transfer: status %0d data %h", $time, status, data);
            errors++;
        end else begin
            want = replies_due.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, status);
                errors++;
            end
            if (data !== want.data) begin
                $display("%0t: data mismatch: expected %h, got %h", $time, want.data, data);
                errors++;
            end
        end
    endfunction
endclass

module tb_shared_buffer_multi_queue;
    localparam int ITEMS_RANDOM    = 1330;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // value
    logic [2:0]  s_axis_tuser  = '0;   // mode, queue_id
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // data_out
    logic [1:0]  m_axis_tuser;         // status

    queue_store_model store;
    int               cycle_count   = 0;
    int               burst_left    = 0;
    bit               hold_off_req  = 1'b0;

    shared_buffer_multi_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                store.check_reply(m_axis_tuser, m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                store.note_request(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata);
            end
        end
    end

    task automatic send_transfer(logic mode, sbmq_pkg::t_qid qid, sbmq_pkg::t_data value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {qid, mode};
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // receiver: ready runs, stall patterns and one long hold-off
    initial begin
        int         span;
        logic [7:0] stall_bits;
        bit         hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                span = $urandom_range(5, 60);
                repeat (span) begin
                    m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                stall_bits = $urandom();
                span       = $urandom_range(8, 64);
                for (int k = 0; k < span; k++) begin
                    m_axis_tready <= stall_bits[3'(k % 8)];
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int             phase_left;
        int             push_pct;
        int             focus;
        logic           mode;
        sbmq_pkg::t_qid qid;
        store      = new();
        phase_left = 0;
        push_pct   = 50;
        focus      = sbmq_pkg::QUEUES;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queues, extreme words, FIFO order, draining past empty
        for (int q = 0; q < sbmq_pkg::QUEUES; q++) begin
            send_transfer(sbmq_pkg::MODE_POP, sbmq_pkg::t_qid'(q), $urandom());
        end
        send_transfer(sbmq_pkg::MODE_PUSH, 2'd0, 32'h7FFF_FFFF);
        send_transfer(sbmq_pkg::MODE_PUSH, 2'd1, 32'h8000_0000);
        send_transfer(sbmq_pkg::MODE_PUSH, 2'd2, 32'h0000_0000);
        send_transfer(sbmq_pkg::MODE_PUSH, 2'd3, 32'hFFFF_FFFF);
        send_transfer(sbmq_pkg::MODE_PUSH, 2'd0, 32'h0000_0001);
        send_transfer(sbmq_pkg::MODE_PUSH, 2'd0, 32'h5555_5555);
        repeat (4) send_transfer(sbmq_pkg::MODE_POP, 2'd0, $urandom());
        repeat (2) send_transfer(sbmq_pkg::MODE_POP, 2'd1, $urandom());
        send_transfer(sbmq_pkg::MODE_POP, 2'd2, $urandom());
        send_transfer(sbmq_pkg::MODE_POP, 2'd3, $urandom());
        send_transfer(sbmq_pkg::MODE_PUSH, 2'd3, 32'hAAAA_AAAA);
        send_transfer(sbmq_pkg::MODE_POP, 2'd3, $urandom());

        // phases lean to push or pop so the store fills and drains repeatedly
        for (int n = 0; n < ITEMS_RANDOM; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 120);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                focus = $urandom_range(0, sbmq_pkg::QUEUES);
            end
            phase_left--;
            mode = ($urandom_range(0, 99) < push_pct) ? sbmq_pkg::MODE_PUSH
                                                        : sbmq_pkg::MODE_POP;
            if (focus < sbmq_pkg::QUEUES && $urandom_range(0, 3) != 0) begin
                qid = sbmq_pkg::t_qid'(focus);
            end else begin
                qid = sbmq_pkg::t_qid'($urandom_range(0, 3));
            end
            if (n == ITEMS_RANDOM / 2) hold_off_req = 1'b1;
            send_transfer(mode, qid, $urandom());
        end
        s_axis_tvalid <= 1'b0;

        while (store.replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Pushes stored %0d, refused on a full store %0d; pops returned %0d, refused %0d",
                 store.pushes_ok, store.pushes_full, store.pops_ok, store.pops_empty);
        $display("Input stalled behind a %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
        if (store.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/sbmq_pkg.sv
rtl/core/shared_buffer_multi_queue.sv
test/tb_shared_buffer_multi_queue.sv
